[rtl/lfu_pkg.sv]
// Shared constants and types of the LFU cache block.
package lfu_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_UPD,
        ST_UPD_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT
    } op_t;

endpackage

[rtl/lfu_scan.sv]
// Scan accumulator: key match, LFU victim and first free slot over one pass.
module lfu_scan #(
    parameter int CAPACITY    = lfu_pkg::CAPACITY_DEF,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF,
    localparam int IW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int RES_W      = 3 + 5 * IW + lfu_pkg::DATA_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       clear,
    input  logic                       en,
    input  logic [lfu_pkg::KEY_W-1:0]  look_key,
    input  logic [IW-1:0]              e_idx,
    input  logic                       e_valid,
    input  logic [lfu_pkg::KEY_W-1:0]  e_key,
    input  logic [lfu_pkg::DATA_W-1:0] e_data,
    input  logic [COUNT_WIDTH-1:0]     e_count,
    input  logic [IW-1:0]              e_rank,
    output logic [RES_W-1:0]           result
);

    typedef struct packed {
        logic                       match;
        logic [IW-1:0]              match_idx;
        logic [lfu_pkg::DATA_W-1:0] match_data;
        logic [IW-1:0]              match_rank;
        logic                       victim_ok;
        logic [IW-1:0]              victim_idx;
        logic [IW-1:0]              victim_rank;
        logic                       free_ok;
        logic [IW-1:0]              free_idx;
    } scan_res_t;

    scan_res_t              res_reg;
    logic [COUNT_WIDTH-1:0] vcount_reg;
    logic                   take_match;
    logic                   take_victim;
    logic                   take_free;

    always_comb begin
        take_match  = e_valid && (e_key == look_key) && !res_reg.match;
        take_victim = e_valid && (!res_reg.victim_ok || (e_count < vcount_reg) ||
                      ((e_count == vcount_reg) && (e_rank > res_reg.victim_rank)));
        take_free   = !e_valid && !res_reg.free_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.match     <= 1'b0;
            res_reg.victim_ok <= 1'b0;
            res_reg.free_ok   <= 1'b0;
        end else if (clear) begin
            res_reg.match     <= 1'b0;
            res_reg.victim_ok <= 1'b0;
            res_reg.free_ok   <= 1'b0;
        end else if (en) begin
            if (take_match) begin
                res_reg.match      <= 1'b1;
                res_reg.match_idx  <= e_idx;
                res_reg.match_data <= e_data;
                res_reg.match_rank <= e_rank;
            end
            // Lowest count wins; on equal counts the older entry (larger rank).
            if (take_victim) begin
                res_reg.victim_ok   <= 1'b1;
                res_reg.victim_idx  <= e_idx;
                res_reg.victim_rank <= e_rank;
                vcount_reg          <= e_count;
            end
            if (take_free) begin
                res_reg.free_ok  <= 1'b1;
                res_reg.free_idx <= e_idx;
            end
        end
    end

    assign result = res_reg;

endmodule

[rtl/lfu_cache_replacement.sv]
// Top level of the LFU key-value cache with its entry memory and sequencer.
// Channels:
//   s_*: one transfer per access; s_tuser is the operation (0 get, 1 put),
//   s_tdata carries the key and, for a put, the value.
//   m_*: exactly one transfer per access, in order; m_tuser is the hit flag,
//   m_tdata the stored value on a get hit, else 0.
//   cfg_*: writes the capacity register (always ready); write it only while
//   no access is in flight. Values above CAPACITY act as CAPACITY; zero
//   makes puts do nothing.
// Timing: a scan pass over all CAPACITY entries finds the key, the victim and
//   a free slot; an access that changes state then makes an update pass that
//   rewrites counts and recency ranks. The memory's one read port sets the
//   pace. A get miss or a put at capacity zero skips the update pass; the
//   next input is taken only once the result has gone to the output register.
// Reset: aresetn (synchronous, active low) empties the cache (valid bits and
//   occupancy clear at once, no sweep) and sets capacity to 16.
// Stall: the result waits in an output register; the next access is taken
//   meanwhile and holds in its last step until the register frees.
module lfu_cache_replacement #(
    parameter int CAPACITY    = lfu_pkg::CAPACITY_DEF,
    parameter int COUNT_WIDTH = lfu_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input transfers
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // [31:0] key, [63:32] value
    input  logic                        s_tuser,   // [0] func
    // Result transfers
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] read_value
    output logic                        m_tuser,   // [0] hit
    // Capacity register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lfu_pkg::CFG_W-1:0]   cfg_data   // capacity
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW    = $clog2(CAPACITY + 1);
    localparam int EW    = (OW > lfu_pkg::CFG_W) ? OW : lfu_pkg::CFG_W;
    localparam int RES_W = 3 + 5 * IW + lfu_pkg::DATA_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    typedef struct packed {
        logic [lfu_pkg::KEY_W-1:0]  key;
        logic [lfu_pkg::DATA_W-1:0] data;
        logic [COUNT_WIDTH-1:0]     count;
        logic [IW-1:0]              rank;
    } entry_t;

    typedef struct packed {
        logic                       match;
        logic [IW-1:0]              match_idx;
        logic [lfu_pkg::DATA_W-1:0] match_data;
        logic [IW-1:0]              match_rank;
        logic                       victim_ok;
        logic [IW-1:0]              victim_idx;
        logic [IW-1:0]              victim_rank;
        logic                       free_ok;
        logic [IW-1:0]              free_idx;
    } scan_res_t;

    // Entry memory: one read and one write port, registered read.
    entry_t mem [CAPACITY];

    lfu_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   cnt_reg, cnt_next;

    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    entry_t                      rd_q;
    logic [IW-1:0]               rd_idx_reg;
    logic                        rd_pend_reg;

    logic                        wr_en;
    entry_t                      wr_data;

    logic [CAPACITY-1:0]         valid_reg;
    logic [CAPACITY-1:0]         valid_next;
    logic [OW-1:0]               occ_reg;
    logic [lfu_pkg::CFG_W-1:0]   cap_reg;

    // Latched access
    logic                        func_reg;
    logic [lfu_pkg::KEY_W-1:0]   key_reg;
    logic [lfu_pkg::DATA_W-1:0]  value_reg;

    // Decision taken after the scan
    lfu_pkg::op_t                op_reg;
    logic [IW-1:0]               tgt_reg;
    logic [IW-1:0]               tgt_rank_reg;
    logic                        ins_ok_reg;
    logic                        evict_reg;
    logic [IW-1:0]               ev_rank_reg;
    logic                        hit_reg;
    logic [lfu_pkg::DATA_W-1:0]  rdv_reg;

    // Output register
    logic                        m_tvalid_reg;
    logic [lfu_pkg::DATA_W-1:0]  m_tdata_reg;
    logic                        m_tuser_reg;

    logic [RES_W-1:0]            scan_bits;
    scan_res_t                   sr;
    logic                        scan_clear;
    logic                        scan_en;

    // Decide-step signals
    logic [EW-1:0]               cap_ext;
    logic [EW-1:0]               eff_cap;
    logic                        full;
    lfu_pkg::op_t                d_op;
    logic                        d_hit;
    logic [lfu_pkg::DATA_W-1:0]  d_rdv;
    logic                        d_evict;
    logic                        d_ins;
    logic [IW-1:0]               d_tgt;
    logic [IW-1:0]               d_tgt_rank;
    logic                        upd_en;
    logic                        out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == lfu_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfu_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rd_en      = 1'b0;
        rd_addr    = cnt_reg;
        scan_clear = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    scan_clear = 1'b1;
                    cnt_next   = '0;
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                rd_en = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = lfu_pkg::ST_SCAN_WAIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lfu_pkg::ST_SCAN_WAIT: begin
                state_next = lfu_pkg::ST_DECIDE;
            end
            lfu_pkg::ST_DECIDE: begin
                cnt_next   = '0;
                state_next = (d_op == lfu_pkg::OP_NONE) ? lfu_pkg::ST_DONE
                                                         : lfu_pkg::ST_UPD;
            end
            lfu_pkg::ST_UPD: begin
                rd_en = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = lfu_pkg::ST_UPD_WAIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lfu_pkg::ST_UPD_WAIT: begin
                state_next = lfu_pkg::ST_DONE;
            end
            lfu_pkg::ST_DONE: begin
                // Hold until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- entry memory ----------------
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[rd_idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= rd_en;
        end
        rd_idx_reg <= rd_addr;
    end

    // ---------------- scan pass ----------------
    assign scan_en = rd_pend_reg &&
                     ((state_reg == lfu_pkg::ST_SCAN) || (state_reg == lfu_pkg::ST_SCAN_WAIT));

    lfu_scan #(
        .CAPACITY    (CAPACITY),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (scan_clear),
        .en       (scan_en),
        .look_key (key_reg),
        .e_idx    (rd_idx_reg),
        .e_valid  (valid_reg[rd_idx_reg]),
        .e_key    (rd_q.key),
        .e_data   (rd_q.data),
        .e_count  (rd_q.count),
        .e_rank   (rd_q.rank),
        .result   (scan_bits)
    );

    assign sr = scan_bits;

    // ---------------- decision ----------------
    always_comb begin
        cap_ext    = EW'(cap_reg);
        eff_cap    = (cap_ext > EW'(CAPACITY)) ? EW'(CAPACITY) : cap_ext;
        full       = EW'(occ_reg) >= eff_cap;
        d_op       = lfu_pkg::OP_NONE;
        d_hit      = 1'b0;
        d_rdv      = '0;
        d_evict    = 1'b0;
        d_ins      = 1'b0;
        d_tgt      = sr.match_idx;
        d_tgt_rank = sr.match_rank;
        if (func_reg == lfu_pkg::FUNC_GET) begin
            if (sr.match) begin
                d_op  = lfu_pkg::OP_TOUCH;
                d_hit = 1'b1;
                d_rdv = sr.match_data;
            end
        end else if (eff_cap != '0) begin
            if (sr.match) begin
                d_op  = lfu_pkg::OP_TOUCH;
                d_hit = 1'b1;
            end else begin
                d_op    = lfu_pkg::OP_INSERT;
                d_evict = full && sr.victim_ok;
                // Lowest free slot once the victim has left.
                priority if (d_evict && (!sr.free_ok || (sr.victim_idx < sr.free_idx))) begin
                    d_ins = 1'b1;
                    d_tgt = sr.victim_idx;
                end else if (sr.free_ok) begin
                    d_ins = 1'b1;
                    d_tgt = sr.free_idx;
                end else begin
                    d_ins = 1'b0;
                end
            end
        end
        // Clear the victim first; an insert may reuse its slot.
        valid_next = valid_reg;
        if (d_evict) begin
            valid_next[sr.victim_idx] = 1'b0;
        end
        if (d_ins) begin
            valid_next[d_tgt] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= lfu_pkg::CFG_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (state_reg == lfu_pkg::ST_DECIDE) begin
                valid_reg <= valid_next;
                occ_reg   <= occ_reg - OW'(d_evict) + OW'(d_ins);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg  <= s_tuser;
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
        end
        if (state_reg == lfu_pkg::ST_DECIDE) begin
            op_reg       <= d_op;
            tgt_reg      <= d_tgt;
            tgt_rank_reg <= d_tgt_rank;
            ins_ok_reg   <= d_ins;
            evict_reg    <= d_evict;
            ev_rank_reg  <= sr.victim_rank;
            hit_reg      <= d_hit;
            rdv_reg      <= d_rdv;
        end
    end

    // ---------------- update pass: read, modify, write back ----------------
    assign upd_en = rd_pend_reg &&
                    ((state_reg == lfu_pkg::ST_UPD) || (state_reg == lfu_pkg::ST_UPD_WAIT));

    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd_q;
        if (upd_en) begin
            unique case (op_reg)
                lfu_pkg::OP_TOUCH: begin
                    if (rd_idx_reg == tgt_reg) begin
                        wr_en        = 1'b1;
                        wr_data.rank = '0;
                        if (rd_q.count != '1) begin
                            wr_data.count = rd_q.count + 1'b1;
                        end
                        if (func_reg == lfu_pkg::FUNC_PUT) begin
                            wr_data.data = value_reg;
                        end
                    end else if (valid_reg[rd_idx_reg]) begin
                        // Age every entry that was newer than the touched one.
                        wr_en = 1'b1;
                        if (rd_q.rank < tgt_rank_reg) begin
                            wr_data.rank = rd_q.rank + 1'b1;
                        end
                    end
                end
                lfu_pkg::OP_INSERT: begin
                    if (ins_ok_reg && (rd_idx_reg == tgt_reg)) begin
                        wr_en         = 1'b1;
                        wr_data.key   = key_reg;
                        wr_data.data  = value_reg;
                        wr_data.count = COUNT_WIDTH'(1);
                        wr_data.rank  = '0;
                    end else if (valid_reg[rd_idx_reg]) begin
                        // Close the victim's gap, then age everything by one.
                        wr_en        = 1'b1;
                        wr_data.rank = rd_q.rank + IW'(ins_ok_reg)
                                     - IW'(evict_reg && (rd_q.rank > ev_rank_reg));
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= rdv_reg;
            m_tuser_reg <= hit_reg;
        end
    end

endmodule
